// ===== rtl/core/lfu_pkg.sv =====
// Shared types and constants for the LFU page replacement block.
// Used by lfu_ctrl, lfu_dp and lfu_page_replacement. Depends on nothing.
`timescale 1ns / 1ps

package lfu_pkg;

  // Port field widths (fixed by the stream format)
  localparam int unsigned PAGE_FIELD_W  = 16;
  localparam int unsigned SLOT_FIELD_W  = 3;
  localparam int unsigned COUNT_FIELD_W = 16;
  localparam int unsigned FAULT_W       = 32;
  localparam int unsigned CFG_W         = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned OUT_TUSER_W = 1;

  // Controller to datapath
  typedef struct packed {
    logic load;    // take a request, restart the frame scan
    logic scan;    // read the next frame
    logic commit;  // update frames, counters and the result register
  } lfu_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;  // frame being read is the last active one
    logic out_busy;   // result register full and not taken this cycle
  } lfu_status_t;

endpackage

// ===== rtl/core/lfu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lfu_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lfu_ctrl.sv =====
// Sequencer for the LFU block: accept, scan, drain, commit.
// Depends on lfu_pkg.
`timescale 1ns / 1ps

module lfu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lfu_pkg::lfu_status_t status_i,
  output lfu_pkg::lfu_cmd_t    cmd_o
);
  import lfu_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the result register can take the new result
        if (!status_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/lfu_dp.sv =====
// Datapath for the LFU block: frame RAMs, valid bits, search registers,
// fault counter, configuration register and result register.
// Depends on lfu_pkg and lfu_ram.
`timescale 1ns / 1ps

module lfu_dp #(
  parameter int unsigned FRAMES     = 8,
  parameter int unsigned PAGE_BITS  = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lfu_pkg::lfu_cmd_t                   cmd_i,
  output lfu_pkg::lfu_status_t                status_o,
  input  logic                                cfg_we_i,
  input  logic [lfu_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic [lfu_pkg::PAGE_FIELD_W-1:0]    in_page_i,
  input  logic                                in_last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                out_hit_o,
  output logic [lfu_pkg::SLOT_FIELD_W-1:0]    out_slot_o,
  output logic                                out_ev_valid_o,
  output logic [lfu_pkg::PAGE_FIELD_W-1:0]    out_ev_page_o,
  output logic [lfu_pkg::COUNT_FIELD_W-1:0]   out_count_o,
  output logic [lfu_pkg::FAULT_W-1:0]         out_fault_o
);
  import lfu_pkg::*;

  localparam int unsigned SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [FAULT_W-1:0]    FAULT_MAX = {FAULT_W{1'b1}};

  // configuration
  logic [CFG_W-1:0]  frames_in_use_q;
  logic [SLOT_W-1:0] last_idx;

  // request
  logic [PAGE_BITS-1:0] page_q;
  logic                 last_q;

  // scan
  logic [SLOT_W-1:0] rd_idx_q;
  logic [SLOT_W-1:0] chk_idx_q;
  logic              chk_vld_q;
  logic [PAGE_BITS-1:0]  rd_page;
  logic [COUNT_BITS-1:0] rd_count;
  logic [COUNT_BITS-1:0] eff_count;
  logic                  chk_frame_valid;

  // search results
  logic                  found_q;
  logic [SLOT_W-1:0]     hit_slot_q;
  logic [COUNT_BITS-1:0] hit_count_q;
  logic [SLOT_W-1:0]     min_slot_q;
  logic [COUNT_BITS-1:0] min_count_q;
  logic [PAGE_BITS-1:0]  min_page_q;

  logic [FRAMES-1:0]  frame_valid_q;
  logic [FAULT_W-1:0] fault_q;

  // commit
  logic [SLOT_W-1:0]     slot;
  logic [COUNT_BITS-1:0] new_count;
  logic [FAULT_W-1:0]    fault_nx;
  logic                  ev_valid;

  // result register
  logic                     out_vld_q;
  logic                     out_hit_q;
  logic [SLOT_FIELD_W-1:0]  out_slot_q;
  logic                     out_ev_valid_q;
  logic [PAGE_FIELD_W-1:0]  out_ev_page_q;
  logic [COUNT_FIELD_W-1:0] out_count_q;
  logic [FAULT_W-1:0]       out_fault_q;

  always_comb begin
    if (frames_in_use_q == '0) begin
      last_idx = '0;
    end else if (32'(frames_in_use_q) >= FRAMES) begin
      last_idx = SLOT_W'(FRAMES - 1);
    end else begin
      last_idx = SLOT_W'(frames_in_use_q - 4'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      frames_in_use_q <= cfg_wdata_i;
    end
  end

  lfu_ram #(.WIDTH(PAGE_BITS), .DEPTH(FRAMES), .AW(SLOT_W)) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && !found_q),
    .waddr_i (slot),
    .wdata_i (page_q),
    .re_i    (cmd_i.scan),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_page)
  );

  lfu_ram #(.WIDTH(COUNT_BITS), .DEPTH(FRAMES), .AW(SLOT_W)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i (slot),
    .wdata_i (new_count),
    .re_i    (cmd_i.scan),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_count)
  );

  assign chk_frame_valid = frame_valid_q[chk_idx_q];
  // an empty frame counts as zero uses
  assign eff_count = chk_frame_valid ? rd_count : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      page_q <= PAGE_BITS'(in_page_i);
      last_q <= in_last_i;
    end
    if (chk_vld_q) begin
      if (!found_q && chk_frame_valid && (rd_page == page_q)) begin
        hit_slot_q  <= chk_idx_q;
        hit_count_q <= rd_count;
      end
      // strict compare keeps the lowest index on a tie
      if ((chk_idx_q == '0) || (eff_count < min_count_q)) begin
        min_slot_q  <= chk_idx_q;
        min_count_q <= eff_count;
        min_page_q  <= rd_page;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      chk_idx_q <= '0;
      chk_vld_q <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      chk_vld_q <= cmd_i.scan;
      chk_idx_q <= rd_idx_q;
      if (cmd_i.load) begin
        rd_idx_q <= '0;
        found_q  <= 1'b0;
      end else if (cmd_i.scan) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (chk_vld_q && chk_frame_valid && (rd_page == page_q)) begin
        found_q <= 1'b1;
      end
    end
  end

  always_comb begin
    slot      = found_q ? hit_slot_q : min_slot_q;
    new_count = found_q ? ((hit_count_q == COUNT_MAX) ? COUNT_MAX : hit_count_q + 1'b1)
                        : COUNT_BITS'(1);
    fault_nx  = (found_q || (fault_q == FAULT_MAX)) ? fault_q : fault_q + 1'b1;
    ev_valid  = !found_q && frame_valid_q[min_slot_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_valid_q <= '0;
      fault_q       <= '0;
    end else if (cmd_i.commit) begin
      if (last_q) begin
        // end of sequence: drop every frame and restart the fault total
        frame_valid_q <= '0;
        fault_q       <= '0;
      end else begin
        frame_valid_q[slot] <= 1'b1;
        fault_q             <= fault_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_hit_q      <= found_q;
      out_slot_q     <= SLOT_FIELD_W'(slot);
      out_ev_valid_q <= ev_valid;
      out_ev_page_q  <= ev_valid ? PAGE_FIELD_W'(min_page_q) : '0;
      out_count_q    <= COUNT_FIELD_W'(new_count);
      out_fault_q    <= fault_nx;
    end
  end

  assign status_o.scan_last = (rd_idx_q == last_idx);
  assign status_o.out_busy  = out_vld_q && !out_ready_i;

  assign out_valid_o    = out_vld_q;
  assign out_hit_o      = out_hit_q;
  assign out_slot_o     = out_slot_q;
  assign out_ev_valid_o = out_ev_valid_q;
  assign out_ev_page_o  = out_ev_page_q;
  assign out_count_o    = out_count_q;
  assign out_fault_o    = out_fault_q;

endmodule

// ===== rtl/core/lfu_page_replacement.sv =====
// Top level of the LFU page replacement block.
// Depends on lfu_pkg, lfu_ctrl, lfu_dp (and lfu_ram through lfu_dp).
//
// Usage:
//   Each request on the slave stream carries one page reference in tdata
//   and an end-of-sequence mark in tlast. Each request yields exactly one
//   result on the master stream: tuser is the hit flag, tdata the frame
//   slot, evicted flag and page, the frame's use count and the fault total.
//   Requests are handled one at a time. A request is accepted, then the
//   frame RAMs are scanned one entry a cycle over the active frames (hit
//   search and minimum search share the pass), then a drain step covers the
//   last registered RAM read, then the commit step loads the result register.
//   The next request is taken in the cycle after commit. The result register
//   decouples the master side: a new request is accepted while a result
//   waits; a stalled receiver only holds the block at commit. Reset empties
//   all frames, clears the fault total and sets the active frame count to 8;
//   no clearing pass is needed. The user must write the frame count register
//   through cfg_we_i only while idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module lfu_page_replacement #(
  parameter int unsigned FRAMES     = 8,
  parameter int unsigned PAGE_BITS  = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // frames_in_use register
  input  logic                                cfg_we_i,
  input  logic [lfu_pkg::CFG_W-1:0]           cfg_wdata_i,
  // request stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lfu_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [15:0] page_number
  input  logic                                s_axis_tlast,   // last_ref
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [2:0] frame_slot, [3] evicted_valid, [19:4] evicted_page,
  // [35:20] slot_use_count, [67:36] fault_total, [71:68] zero
  output logic [lfu_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic [lfu_pkg::OUT_TUSER_W-1:0]     m_axis_tuser    // [0] hit
);
  import lfu_pkg::*;

  lfu_cmd_t    cmd;
  lfu_status_t status;

  logic                     out_hit;
  logic [SLOT_FIELD_W-1:0]  out_slot;
  logic                     out_ev_valid;
  logic [PAGE_FIELD_W-1:0]  out_ev_page;
  logic [COUNT_FIELD_W-1:0] out_count;
  logic [FAULT_W-1:0]       out_fault;

  lfu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lfu_dp #(
    .FRAMES     (FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_page_i      (s_axis_tdata[PAGE_FIELD_W-1:0]),
    .in_last_i      (s_axis_tlast),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_hit_o      (out_hit),
    .out_slot_o     (out_slot),
    .out_ev_valid_o (out_ev_valid),
    .out_ev_page_o  (out_ev_page),
    .out_count_o    (out_count),
    .out_fault_o    (out_fault)
  );

  // pack the result fields, first field in the low bits, zero pad on top
  assign m_axis_tdata = {4'b0, out_fault, out_count, out_ev_page, out_ev_valid, out_slot};
  assign m_axis_tuser = out_hit;

endmodule

// ===== dv/lfu_page_replacement_test.sv =====
// Self-checking testbench for lfu_page_replacement: drives page references on the
// request stream and checks every result against a predictor kept in this file,
// or a hand-written result. Depends on lfu_pkg and the lfu_page_replacement RTL.
`timescale 1ns / 1ps

module lfu_page_replacement_test;
  import lfu_pkg::*;

  localparam int unsigned FRAME_CNT   = 8;
  localparam int unsigned IDLE_LIMIT  = 3000;   // cycles with no handshake at all
  localparam int unsigned HOLD_CYCLES = 600;    // long receiver hold-off
  localparam int unsigned RAND_PHASES = 12;
  localparam int unsigned PHASE_REFS  = 136;

  typedef struct packed {
    logic                     hit;
    logic [SLOT_FIELD_W-1:0]  slot;
    logic                     ev_valid;
    logic [PAGE_FIELD_W-1:0]  ev_page;
    logic [COUNT_FIELD_W-1:0] use_cnt;
    logic [FAULT_W-1:0]       faults;
  } lfu_result_t;

  typedef enum logic {ROW_PAGE, ROW_FRAMES} row_kind_e;
  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  typedef struct packed {
    logic [PAGE_FIELD_W-1:0] page;
    logic                    last;
    logic                    known;  // want holds a hand-written result
    lfu_result_t             want;
  } page_ref_t;

  typedef struct packed {
    row_kind_e   kind;
    logic [CFG_W-1:0] frames;
    page_ref_t   req;
  } plan_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_W-1:0]       cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  lfu_page_replacement dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Predictor copy of the frame table
  logic [PAGE_FIELD_W-1:0]  model_page  [FRAME_CNT];
  logic                     model_valid [FRAME_CNT];
  logic [COUNT_FIELD_W-1:0] model_count [FRAME_CNT];
  logic [FAULT_W-1:0]       model_faults;
  logic [CFG_W-1:0]         model_frames;

  page_ref_t   page_refs[$];        // requests still to be offered
  lfu_result_t pending_results[$];  // results owed by the block, oldest first
  plan_row_t   directed_plan[$];

  int unsigned mismatches;
  bit          random_started;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void clear_frames();
    int i;
    for (i = 0; i < FRAME_CNT; i++) begin
      model_page[i]  = '0;
      model_valid[i] = 1'b0;
      model_count[i] = '0;
    end
    model_faults = '0;
  endfunction

  // Look up one page, update the frame table and return the result it yields
  function automatic lfu_result_t replace_page(input logic [PAGE_FIELD_W-1:0] page,
                                               input logic last);
    int unsigned n;
    int unsigned slot;
    int unsigned i;
    bit          found;
    lfu_result_t r;
    n = (model_frames == 0) ? 1 : (model_frames > FRAME_CNT) ? FRAME_CNT : 32'(model_frames);
    r = '0;
    found = 1'b0;
    slot = 0;
    for (i = 0; i < n; i++) begin
      if (!found && model_valid[i] && model_page[i] == page) begin
        found = 1'b1;
        slot = i;
      end
    end
    if (found) begin
      if (model_count[slot] != {COUNT_FIELD_W{1'b1}})
        model_count[slot] = model_count[slot] + 1'b1;
    end else begin
      // lowest count wins, ties go to the lowest index; empty frames sit at 0
      for (i = 1; i < n; i++)
        if (model_count[i] < model_count[slot]) slot = i;
      if (model_valid[slot]) begin
        r.ev_valid = 1'b1;
        r.ev_page  = model_page[slot];
      end
      model_page[slot]  = page;
      model_valid[slot] = 1'b1;
      model_count[slot] = COUNT_FIELD_W'(1);
      if (model_faults != {FAULT_W{1'b1}}) model_faults = model_faults + 1'b1;
    end
    r.hit     = found;
    r.slot    = slot[SLOT_FIELD_W-1:0];
    r.use_cnt = model_count[slot];
    r.faults  = model_faults;
    if (last) clear_frames();
    return r;
  endfunction

  function automatic plan_row_t page_row(input logic [PAGE_FIELD_W-1:0] page, input logic last);
    plan_row_t row;
    row = '0;
    row.kind     = ROW_PAGE;
    row.req.page = page;
    row.req.last = last;
    return row;
  endfunction

  function automatic plan_row_t known_row(input logic [PAGE_FIELD_W-1:0] page, input logic last,
                                          input logic hit, input logic [2:0] slot,
                                          input logic ev_valid,
                                          input logic [PAGE_FIELD_W-1:0] ev_page,
                                          input logic [COUNT_FIELD_W-1:0] use_cnt,
                                          input logic [FAULT_W-1:0] faults);
    plan_row_t row;
    row = page_row(page, last);
    row.req.known = 1'b1;
    row.req.want  = '{hit, slot, ev_valid, ev_page, use_cnt, faults};
    return row;
  endfunction

  function automatic plan_row_t frames_row(input logic [CFG_W-1:0] frames);
    plan_row_t row;
    row = '0;
    row.kind   = ROW_FRAMES;
    row.frames = frames;
    return row;
  endfunction

  task automatic compare_field(input string name, input logic [FAULT_W-1:0] want,
                               input logic [FAULT_W-1:0] got);
    if (want !== got) begin
      $error("result field %s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Request side: bursts of random length separated by random gaps
  initial begin
    page_ref_t   head;
    lfu_result_t predicted;
    int unsigned burst_left;
    int unsigned gap_left;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    burst_left    = 0;
    gap_left      = 0;
    forever begin
      @(posedge clk_i);
      if (s_axis_tvalid && s_axis_tready) begin
        head = page_refs.pop_front();
        predicted = replace_page(head.page, head.last);
        pending_results.push_back(head.known ? head.want : predicted);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          // now and then a long burst with no idling at all
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 10);
          gap_left   = $urandom_range(1, 28);
        end
      end else if (!s_axis_tvalid && gap_left > 0) begin
        gap_left--;
      end
      if (gap_left == 0 && page_refs.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= page_refs[0].page;
        s_axis_tlast  <= page_refs[0].last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result side: check each result, then stall on a changing pattern
  initial begin
    lfu_result_t want;
    lfu_result_t got;
    rx_mode_e    rx_mode;
    int unsigned stretch_left;
    int unsigned hold_left;
    bit          held;
    bit          toggle;
    m_axis_tready = 1'b0;
    rx_mode       = RX_STEADY;
    stretch_left  = 0;
    hold_left     = 0;
    held          = 1'b0;
    toggle        = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.hit      = m_axis_tuser[0];
        got.slot     = m_axis_tdata[2:0];
        got.ev_valid = m_axis_tdata[3];
        got.ev_page  = m_axis_tdata[19:4];
        got.use_cnt  = m_axis_tdata[35:20];
        got.faults   = m_axis_tdata[67:36];
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding: tdata %0h tuser %0h",
                 m_axis_tdata, m_axis_tuser);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          compare_field("hit", FAULT_W'(want.hit), FAULT_W'(got.hit));
          compare_field("frame_slot", FAULT_W'(want.slot), FAULT_W'(got.slot));
          compare_field("evicted_valid", FAULT_W'(want.ev_valid), FAULT_W'(got.ev_valid));
          compare_field("evicted_page", FAULT_W'(want.ev_page), FAULT_W'(got.ev_page));
          compare_field("slot_use_count", FAULT_W'(want.use_cnt), FAULT_W'(got.use_cnt));
          compare_field("fault_total", want.faults, got.faults);
        end
      end
      // once, at the start of the random part: hold off long enough to fill the block
      if (random_started && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          stretch_left = $urandom_range(8, 60);
          rx_mode      = rx_mode_e'($urandom_range(0, 3));
        end
        stretch_left--;
        case (rx_mode)
          RX_STEADY: m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: begin
            toggle = ~toggle;
            m_axis_tready <= toggle;
          end
        endcase
      end
    end
  end

  // Watchdog: end the run if no handshake happens for too long
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // Wait until every request is taken and every result is back, then let the
  // block settle for more than one request's latency
  task automatic drain_and_settle();
    while (page_refs.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] frames);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= frames;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    model_frames  = frames;
  endtask

  // One random phase: sequences over a small working set so that hits and
  // evictions are common, with stray pages and stray last marks as noise
  task automatic queue_random_refs(input int unsigned count);
    logic [PAGE_FIELD_W-1:0] pool [12];
    page_ref_t   req;
    int unsigned made;
    int unsigned len;
    int unsigned pool_n;
    int unsigned j;
    int unsigned k;
    int unsigned pick;
    bit          close;
    made = 0;
    while (made < count) begin
      len    = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      pool_n = $urandom_range(1, 12);
      for (j = 0; j < pool_n; j++)
        pool[j] = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
                                              : 16'($urandom_range(0, 16'hFFFF));
      close = ($urandom_range(0, 9) != 0);  // else the sequence runs into the next one
      for (k = 0; k < len && made < count; k++) begin
        req  = '0;
        pick = $urandom_range(0, 99);
        if (pick < 85)
          req.page = pool[$urandom_range(0, pool_n - 1)];
        else if (pick < 95)
          req.page = pool[$urandom_range(0, pool_n - 1)] ^ (16'h1 << $urandom_range(0, 15));
        else
          req.page = 16'($urandom_range(0, 16'hFFFF));
        req.last = (k == len - 1) ? close : ($urandom_range(0, 49) == 0);
        page_refs.push_back(req);
        made++;
      end
    end
  endtask

  initial begin
    int unsigned ph;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    random_started = 1'b0;
    mismatches     = 0;
    model_frames   = CFG_RESET;
    clear_frames();

    // Directed plan, starting from the reset state with eight frames
    directed_plan.push_back(known_row(16'h0000, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0, 16'd1, 32'd1));
    directed_plan.push_back(known_row(16'hFFFF, 1'b0, 1'b0, 3'd1, 1'b0, 16'h0, 16'd1, 32'd2));
    directed_plan.push_back(known_row(16'h0000, 1'b0, 1'b1, 3'd0, 1'b0, 16'h0, 16'd2, 32'd2));
    directed_plan.push_back(known_row(16'hFFFF, 1'b0, 1'b1, 3'd1, 1'b0, 16'h0, 16'd2, 32'd2));
    directed_plan.push_back(page_row(16'h0003, 1'b0));
    directed_plan.push_back(page_row(16'h0004, 1'b0));
    directed_plan.push_back(page_row(16'h0005, 1'b0));
    directed_plan.push_back(page_row(16'h0006, 1'b0));
    directed_plan.push_back(page_row(16'h0007, 1'b0));
    directed_plan.push_back(page_row(16'h0008, 1'b0));
    directed_plan.push_back(page_row(16'h8000, 1'b0));   // all full: evict on a tie
    directed_plan.push_back(page_row(16'h0000, 1'b1));   // hit that ends the sequence
    directed_plan.push_back(known_row(16'h1234, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0, 16'd1, 32'd1));
    directed_plan.push_back(page_row(16'h00A0, 1'b0));
    directed_plan.push_back(page_row(16'h00A1, 1'b0));
    directed_plan.push_back(page_row(16'h00A2, 1'b0));
    // shrink mid-sequence: upper frames are hidden but keep their pages
    directed_plan.push_back(frames_row(4'd2));
    directed_plan.push_back(page_row(16'h00A2, 1'b0));
    directed_plan.push_back(frames_row(4'd8));
    directed_plan.push_back(page_row(16'h00A1, 1'b1));
    // zero frames acts as one
    directed_plan.push_back(frames_row(4'd0));
    directed_plan.push_back(known_row(16'h7FFF, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0, 16'd1, 32'd1));
    directed_plan.push_back(known_row(16'h0001, 1'b0, 1'b0, 3'd0, 1'b1, 16'h7FFF, 16'd1,
                                      32'd2));
    directed_plan.push_back(page_row(16'h0001, 1'b1));
    // above the built count acts as eight; last mark on the very first reference
    directed_plan.push_back(frames_row(4'd15));
    directed_plan.push_back(known_row(16'hFFFF, 1'b1, 1'b0, 3'd0, 1'b0, 16'h0, 16'd1, 32'd1));
    directed_plan.push_back(known_row(16'hFFFF, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0, 16'd1, 32'd1));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_FRAMES) begin
        drain_and_settle();
        write_frames(directed_plan[i].frames);
      end else begin
        page_refs.push_back(directed_plan[i].req);
      end
    end

    // Random phases over a spread of frame counts, extremes first
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      drain_and_settle();
      case (ph)
        0: write_frames(4'd1);
        1: write_frames(4'd8);
        2: write_frames(4'd0);
        3: write_frames(4'd15);
        default: write_frames(($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                           : 4'($urandom_range(1, 8)));
      endcase
      random_started = 1'b1;
      queue_random_refs(PHASE_REFS);
    end

    drain_and_settle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
